>>> hdl/kte_pkg.sv
// ----------------------------------------------------------------------------
// kte_pkg
// Shared widths, codes and control records for the key tracked envelope.
// ----------------------------------------------------------------------------
package kte_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int LEVEL_BITS  = 16;
    localparam int KEY_BITS    = 16;
    localparam int AMT_BITS    = 16;
    localparam int FUNC_BITS   = 2;
    localparam int PHASE_BITS  = 3;

    localparam int CNT_W     = LENGTH_BITS + 1;
    localparam int NUM_SLOTS = 5;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int MAG_W     = AMT_BITS + 1;

    localparam int     SCALE_SH   = 15;
    localparam longint KEY_FULL   = (64'd1 << KEY_BITS) - 1;
    localparam longint SCALE_DEN  = (64'd1 << SCALE_SH) * KEY_FULL;
    localparam int     FACT_W     = $clog2(SCALE_DEN + 1);

    localparam int AW      = (FACT_W > LEVEL_BITS) ? FACT_W : LEVEL_BITS;
    localparam int BW      = CNT_W;
    localparam int DW      = LENGTH_BITS;
    localparam int QW      = (LENGTH_BITS > LEVEL_BITS) ? LENGTH_BITS : LEVEL_BITS;
    localparam int PW      = AW + BW;
    localparam int STEP_W  = $clog2(((BW > QW) ? BW : QW) + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (LENGTH_BITS > LEVEL_BITS) ?
                                ((LENGTH_BITS > AMT_BITS) ? LENGTH_BITS : AMT_BITS) :
                                ((LEVEL_BITS > AMT_BITS) ? LEVEL_BITS : AMT_BITS);

    localparam logic [SLOT_W-1:0] SL_DELAY   = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SL_ATTACK  = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SL_HOLD    = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SL_DECAY   = SLOT_W'(3);
    localparam logic [SLOT_W-1:0] SL_RELEASE = SLOT_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY,
        CFG_ATTACK,
        CFG_HOLD,
        CFG_DECAY,
        CFG_SUSTAIN,
        CFG_RELEASE,
        CFG_KEY_AMT
    } t_cfg_idx;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_TICK,
        FN_TRIGGER,
        FN_RELEASE
    } t_func;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_IDLE,
        PH_DELAY,
        PH_ATTACK,
        PH_HOLD,
        PH_DECAY,
        PH_SUSTAIN,
        PH_RELEASE
    } t_phase;

    typedef struct packed {
        logic              accept;
        logic              fact_load;
        logic              md_start;
        logic              md_trig;
        logic              len_wr;
        logic              commit;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic                 need_md;
        logic                 md_done;
        logic                 out_free;
    } t_sts;

endpackage

>>> hdl/kte_muldiv.sv
// ----------------------------------------------------------------------------
// kte_muldiv
// Sequential unit computing floor(a * b / d), shift-add then restoring divide,
// or floor(a * b / SCALE_DEN) by shift-add then a constant reduction.
// ----------------------------------------------------------------------------
module kte_muldiv (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_by_den,
    input  logic [kte_pkg::AW-1:0] i_a,
    input  logic [kte_pkg::BW-1:0] i_b,
    input  logic [kte_pkg::DW-1:0] i_d,
    output logic                 o_done,
    output logic [kte_pkg::QW-1:0] o_q
);
    import kte_pkg::*;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_RED
    } t_md_state;

    t_md_state         r_state;
    logic [PW-1:0]     r_acc;
    logic [AW-1:0]     r_a;
    logic [BW-1:0]     r_b;
    logic [DW-1:0]     r_d;
    logic [DW-1:0]     r_rem;
    logic [QW-1:0]     r_quo;
    logic [STEP_W-1:0] r_step;
    logic              r_done;
    logic              r_by_den;

    logic [PW-1:0]     n_acc;
    logic [DW:0]       rem_sh;
    logic [DW:0]       rem_sub;
    logic              rem_ge;
    logic [DW-1:0]     n_rem;

    logic [PW-1:0]     red_y;
    logic [PW-1:0]     red_h;
    logic [PW-1:0]     red_s;
    logic [PW-1:0]     red_h2;
    logic [PW-1:0]     red_t;
    logic [PW-1:0]     red_q;

    always_comb begin
        n_acc   = {r_acc[PW-2:0], 1'b0} + (r_b[BW-1] ? PW'(r_a) : '0);
        rem_sh  = {r_rem, r_quo[QW-1]};
        rem_ge  = rem_sh >= {1'b0, r_d};
        rem_sub = rem_sh - {1'b0, r_d};
        n_rem   = rem_ge ? DW'(rem_sub) : DW'(rem_sh);
    end

    // divide by 2^KEY_BITS - 1 after the power of two, folding high bits twice
    always_comb begin
        red_y  = r_acc >> SCALE_SH;
        red_h  = red_y >> KEY_BITS;
        red_s  = red_h + PW'(red_y[KEY_BITS-1:0]);
        red_h2 = red_s >> KEY_BITS;
        red_t  = red_h2 + PW'(red_s[KEY_BITS-1:0]);
        red_q  = red_h + red_h2 + PW'(red_t >= PW'(KEY_FULL));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                MD_IDLE: begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_acc    <= '0;
                        r_a      <= i_a;
                        r_b      <= i_b;
                        r_d      <= i_d;
                        r_by_den <= i_by_den;
                        r_step   <= STEP_W'(BW - 1);
                        r_state  <= MD_MUL;
                    end
                end
                MD_MUL: begin
                    r_acc <= n_acc;
                    r_b   <= {r_b[BW-2:0], 1'b0};
                    if (r_step == '0) begin
                        if (r_by_den) begin
                            r_state <= MD_RED;
                        end else begin
                            r_rem   <= DW'(n_acc >> QW);
                            r_quo   <= n_acc[QW-1:0];
                            r_step  <= STEP_W'(QW - 1);
                            r_state <= MD_DIV;
                        end
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                MD_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[QW-2:0], rem_ge};
                    if (r_step == '0) begin
                        r_done  <= 1'b1;
                        r_state <= MD_IDLE;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                MD_RED: begin
                    r_quo   <= QW'(red_q);
                    r_done  <= 1'b1;
                    r_state <= MD_IDLE;
                end
                default: r_state <= MD_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_q    = r_quo;

endmodule

>>> hdl/kte_dp.sv
// ----------------------------------------------------------------------------
// kte_dp
// Envelope datapath: config registers, envelope state, key scaling, output.
// ----------------------------------------------------------------------------
module kte_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  kte_pkg::t_cmd                       i_cmd,
    output kte_pkg::t_sts                       o_sts,
    input  logic [kte_pkg::FUNC_BITS-1:0]       i_func,
    input  logic [kte_pkg::KEY_BITS-1:0]        i_key,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kte_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [kte_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [kte_pkg::LEVEL_BITS-1:0]      o_level,
    output logic [kte_pkg::PHASE_BITS-1:0]      o_phase
);
    import kte_pkg::*;

    localparam logic [LEVEL_BITS-1:0] FULL = '1;

    logic [LENGTH_BITS-1:0] r_cfg_len [NUM_SLOTS];
    logic [LEVEL_BITS-1:0]  r_cfg_sus;
    logic [AMT_BITS-1:0]    r_cfg_amt;

    logic [FUNC_BITS-1:0]   r_func;
    logic [KEY_BITS-1:0]    r_key;
    logic [FACT_W-1:0]      r_factor;

    logic [LENGTH_BITS-1:0] r_scaled [NUM_SLOTS];
    t_phase                 r_phase;
    logic [CNT_W-1:0]       r_cnt;
    logic [LEVEL_BITS-1:0]  r_level;
    logic [LEVEL_BITS-1:0]  r_as;
    logic [LEVEL_BITS-1:0]  r_rs;
    logic [LEVEL_BITS-1:0]  r_sus;

    logic                   r_out_valid;
    logic [LEVEL_BITS-1:0]  r_out_level;
    logic [PHASE_BITS-1:0]  r_out_phase;

    t_phase                 n_phase;
    logic [CNT_W-1:0]       n_cnt;
    logic [LEVEL_BITS-1:0]  n_level;
    logic [LEVEL_BITS-1:0]  n_as;
    logic [LEVEL_BITS-1:0]  n_rs;
    logic [LEVEL_BITS-1:0]  n_sus;

    logic                   amt_neg;
    logic [MAG_W-1:0]       mag;
    logic [KEY_BITS-1:0]    key_term;
    logic [MAG_W+KEY_BITS-1:0] fprod;
    logic [FACT_W-1:0]      n_factor;

    logic [LENGTH_BITS-1:0] len_cur;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   adv;
    t_phase                 adv_phase;
    logic [LEVEL_BITS-1:0]  q_lvl;

    logic [AW-1:0]          md_a;
    logic [BW-1:0]          md_b;
    logic [DW-1:0]          md_d;
    logic                   md_done;
    logic [QW-1:0]          md_q;
    logic                   out_free;

    kte_muldiv u_muldiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.md_start),
        .i_by_den (i_cmd.md_trig),
        .i_a      (md_a),
        .i_b      (md_b),
        .i_d      (md_d),
        .o_done   (md_done),
        .o_q      (md_q)
    );

    // key tracking factor
    always_comb begin
        amt_neg  = r_cfg_amt[AMT_BITS-1];
        mag      = amt_neg ? ((MAG_W'(1) << AMT_BITS) - MAG_W'(r_cfg_amt))
                           : MAG_W'(r_cfg_amt);
        key_term = amt_neg ? r_key : (KEY_BITS'(KEY_FULL) - r_key);
        fprod    = (MAG_W+KEY_BITS)'(mag) * (MAG_W+KEY_BITS)'(key_term);
        n_factor = FACT_W'(SCALE_DEN) - FACT_W'(fprod);
    end

    always_comb begin
        unique case (r_phase)
            PH_DELAY:   begin len_cur = r_scaled[SL_DELAY];   adv_phase = PH_ATTACK;  end
            PH_ATTACK:  begin len_cur = r_scaled[SL_ATTACK];  adv_phase = PH_HOLD;    end
            PH_HOLD:    begin len_cur = r_scaled[SL_HOLD];    adv_phase = PH_DECAY;   end
            PH_DECAY:   begin len_cur = r_scaled[SL_DECAY];   adv_phase = PH_SUSTAIN; end
            PH_RELEASE: begin len_cur = r_scaled[SL_RELEASE]; adv_phase = PH_IDLE;    end
            default:    begin len_cur = '0;                   adv_phase = r_phase;    end
        endcase
        cnt_inc = r_cnt + 1'b1;
        adv     = cnt_inc > CNT_W'(len_cur);
        q_lvl   = LEVEL_BITS'(md_q);
    end

    // interpolation or scaling operands
    always_comb begin
        md_b = r_cnt;
        md_d = DW'(len_cur);
        unique case (r_phase)
            PH_ATTACK: md_a = AW'(FULL - r_as);
            PH_DECAY:  md_a = AW'(FULL - r_sus);
            default:   md_a = AW'(r_rs);
        endcase
        if (i_cmd.md_trig) begin
            md_a = AW'(r_factor);
            md_b = BW'(r_cfg_len[i_cmd.slot]);
        end
    end

    // next envelope state at commit
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_level = r_level;
        n_as    = r_as;
        n_rs    = r_rs;
        n_sus   = r_sus;
        unique case (r_func)
            FN_TICK: begin
                unique case (r_phase)
                    PH_DELAY: begin
                        if (len_cur != '0) begin
                            n_level = '0;
                        end
                    end
                    PH_ATTACK: begin
                        n_level = (len_cur == '0) ? FULL : r_as + q_lvl;
                    end
                    PH_HOLD: begin
                        n_level = FULL;
                    end
                    PH_DECAY: begin
                        n_level = (len_cur == '0 || adv) ? r_sus : FULL - q_lvl;
                    end
                    PH_SUSTAIN: begin
                    end
                    PH_RELEASE: begin
                        if (len_cur == '0) begin
                            n_level = '0;
                        end else if (r_cnt == '0) begin
                            n_rs = r_level;
                        end else begin
                            n_level = r_rs - q_lvl;
                        end
                    end
                    default: begin
                        n_level = '0;
                    end
                endcase
                if (r_phase != PH_IDLE && r_phase != PH_SUSTAIN) begin
                    if (adv) begin
                        n_phase = adv_phase;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            end
            FN_TRIGGER: begin
                n_phase = PH_DELAY;
                n_cnt   = '0;
                n_as    = r_level;
                n_sus   = r_cfg_sus;
            end
            FN_RELEASE: begin
                n_phase = PH_RELEASE;
                n_cnt   = '0;
            end
            default: begin
            end
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_cfg_len[i] <= '0;
                r_scaled[i]  <= '0;
            end
            r_cfg_sus   <= '0;
            r_cfg_amt   <= '0;
            r_phase     <= PH_IDLE;
            r_cnt       <= '0;
            r_level     <= '0;
            r_as        <= '0;
            r_rs        <= '0;
            r_sus       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DELAY:   r_cfg_len[SL_DELAY]   <= LENGTH_BITS'(i_cfg_data);
                    CFG_ATTACK:  r_cfg_len[SL_ATTACK]  <= LENGTH_BITS'(i_cfg_data);
                    CFG_HOLD:    r_cfg_len[SL_HOLD]    <= LENGTH_BITS'(i_cfg_data);
                    CFG_DECAY:   r_cfg_len[SL_DECAY]   <= LENGTH_BITS'(i_cfg_data);
                    CFG_SUSTAIN: r_cfg_sus             <= LEVEL_BITS'(i_cfg_data);
                    CFG_RELEASE: r_cfg_len[SL_RELEASE] <= LENGTH_BITS'(i_cfg_data);
                    CFG_KEY_AMT: r_cfg_amt             <= AMT_BITS'(i_cfg_data);
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept) begin
                r_func <= i_func;
                r_key  <= i_key;
            end
            if (i_cmd.fact_load) begin
                r_factor <= n_factor;
            end
            if (i_cmd.len_wr) begin
                r_scaled[i_cmd.slot] <= LENGTH_BITS'(md_q);
            end
            if (i_cmd.commit) begin
                r_phase     <= n_phase;
                r_cnt       <= n_cnt;
                r_level     <= n_level;
                r_as        <= n_as;
                r_rs        <= n_rs;
                r_sus       <= n_sus;
                r_out_valid <= 1'b1;
                r_out_level <= n_level;
                r_out_phase <= n_phase;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.func     = r_func;
        o_sts.need_md  = ((r_phase == PH_ATTACK || r_phase == PH_DECAY) && len_cur != '0)
                      || (r_phase == PH_RELEASE && len_cur != '0 && r_cnt != '0);
        o_sts.md_done  = md_done;
        o_sts.out_free = out_free;
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_level     = r_out_level;
    assign o_phase     = r_out_phase;

endmodule

>>> hdl/kte_ctrl.sv
// ----------------------------------------------------------------------------
// kte_ctrl
// Sequencer: decodes a word and steps the datapath through its operations.
// ----------------------------------------------------------------------------
module kte_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  kte_pkg::t_sts i_sts,
    output kte_pkg::t_cmd o_cmd
);
    import kte_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_TRIG_GO,
        S_TRIG_WAIT,
        S_WAIT,
        S_COMMIT
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_slot  = r_slot;
        o_cmd.slot = r_slot;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.func == FN_TRIGGER) begin
                    o_cmd.fact_load = 1'b1;
                    n_slot          = SL_DELAY;
                    n_state         = S_TRIG_GO;
                end else if (i_sts.func == FN_TICK && i_sts.need_md) begin
                    o_cmd.md_start = 1'b1;
                    n_state        = S_WAIT;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_TRIG_GO: begin
                o_cmd.md_start = 1'b1;
                o_cmd.md_trig  = 1'b1;
                n_state        = S_TRIG_WAIT;
            end
            S_TRIG_WAIT: begin
                if (i_sts.md_done) begin
                    o_cmd.len_wr = 1'b1;
                    if (r_slot == SL_RELEASE) begin
                        n_state = S_COMMIT;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = S_TRIG_GO;
                    end
                end
            end
            S_WAIT: begin
                if (i_sts.md_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= SL_DELAY;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> hdl/key_tracked_dahdsr_envelope.sv
// ----------------------------------------------------------------------------
// key_tracked_dahdsr_envelope
// Linear delay-attack-hold-decay-sustain-release envelope with key tracking.
//
// channel   direction  handshake              word
// in        sink       i_in_valid/o_in_stall  i_func, i_key
// out       source     o_out_valid/i_out_stall o_level, o_phase
// cfg       sink       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// one word at a time; a shared shift-add multiplier with a restoring divider
// sets the pace between an accept and the next possible accept
// tick with interpolation: shift-add multiply, then restoring divide
// trigger: five key scalings, each a multiply and a constant reduction
// other words: no multiply; a stalled output delays the commit by the stall
// synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
module key_tracked_dahdsr_envelope (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [kte_pkg::FUNC_BITS-1:0]       i_func,
    input  logic [kte_pkg::KEY_BITS-1:0]        i_key,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [kte_pkg::LEVEL_BITS-1:0]      o_level,
    output logic [kte_pkg::PHASE_BITS-1:0]      o_phase,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kte_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [kte_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import kte_pkg::*;

    t_cmd cmd;
    t_sts sts;

    kte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kte_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_level     (o_level),
        .o_phase     (o_phase)
    );

endmodule

>>> tb/sv/key_tracked_dahdsr_envelope_tb.sv
// ----------------------------------------------------------------------------
// key_tracked_dahdsr_envelope_tb
// Self-checking bench for the key tracked envelope. A queue-fed driver sends
// tick, trigger, release and unused-code words. Random gaps and output stalls are
// applied. A word-level predictor works out level and phase for every accepted
// word, and a monitor compares each result with the oldest prediction.
// Registers are rewritten between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module key_tracked_dahdsr_envelope_tb;
    import kte_pkg::*;

    localparam logic [FUNC_BITS-1:0] FN_UNUSED      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam longint unsigned      FULL_LVL       = (64'd1 << LEVEL_BITS) - 1;
    localparam longint unsigned      LEN_MAX        = (64'd1 << LENGTH_BITS) - 1;
    localparam int                   CYCLE_LIMIT    = 2000000;

    typedef struct {
        logic [FUNC_BITS-1:0] func;
        logic [KEY_BITS-1:0]  key;
    } t_word;

    typedef struct {
        logic [LEVEL_BITS-1:0] level;
        t_phase                phase;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [FUNC_BITS-1:0]  i_func = '0;
    logic [KEY_BITS-1:0]   i_key = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [LEVEL_BITS-1:0] o_level;
    logic [PHASE_BITS-1:0] o_phase;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    key_tracked_dahdsr_envelope uut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    longint unsigned base_len[NUM_SLOTS];
    longint unsigned scaled_len[NUM_SLOTS];
    longint unsigned sustain_cfg, sustain_held;
    logic [15:0]     key_amt_cfg;
    t_phase          env_phase;
    longint unsigned env_count, env_level, env_attack_start, env_release_start;

    t_word   pending_words[$];
    t_result expected_results[$];
    int      err_count = 0;
    int      words_checked = 0;
    int      triggers_sent = 0;
    int      cycle_count = 0;
    bit      calm = 1'b0;

    function automatic bit env_advance(input longint unsigned len, input t_phase nxt);
        env_count++;
        if (env_count > len) begin
            env_phase = nxt;
            env_count = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void env_trigger(input logic [KEY_BITS-1:0] k);
        longint unsigned mag, factor;
        if (key_amt_cfg[15]) begin
            mag    = 64'd65536 - key_amt_cfg;
            factor = SCALE_DEN - mag * k;
        end else begin
            mag    = key_amt_cfg;
            factor = SCALE_DEN - mag * (KEY_FULL - k);
        end
        for (int i = 0; i < NUM_SLOTS; i++) scaled_len[i] = (base_len[i] * factor) / SCALE_DEN;
        env_phase        = PH_DELAY;
        env_count        = 0;
        env_attack_start = env_level;
        sustain_held     = sustain_cfg;
    endfunction

    function automatic void env_tick();
        longint unsigned len;
        case (env_phase)
            PH_DELAY: begin
                len = scaled_len[SL_DELAY];
                if (len != 0) env_level = 0;
                void'(env_advance(len, PH_ATTACK));
            end
            PH_ATTACK: begin
                len = scaled_len[SL_ATTACK];
                if (len == 0) env_level = FULL_LVL;
                else env_level = env_attack_start
                                 + ((FULL_LVL - env_attack_start) * env_count) / len;
                void'(env_advance(len, PH_HOLD));
            end
            PH_HOLD: begin
                env_level = FULL_LVL;
                void'(env_advance(scaled_len[SL_HOLD], PH_DECAY));
            end
            PH_DECAY: begin
                len = scaled_len[SL_DECAY];
                if (len == 0) env_level = sustain_held;
                else env_level = FULL_LVL - ((FULL_LVL - sustain_held) * env_count) / len;
                if (env_advance(len, PH_SUSTAIN)) env_level = sustain_held;
            end
            PH_SUSTAIN: ;
            PH_RELEASE: begin
                len = scaled_len[SL_RELEASE];
                if (len == 0) env_level = 0;
                else if (env_count == 0) env_release_start = env_level;
                else env_level = env_release_start
                                 - (env_release_start * env_count) / len;
                void'(env_advance(len, PH_IDLE));
            end
            default: env_level = 0;
        endcase
        env_level &= FULL_LVL;
    endfunction

    function automatic t_result env_step(input t_word w);
        t_result r;
        case (w.func)
            FN_TICK:    env_tick();
            FN_TRIGGER: env_trigger(w.key);
            FN_RELEASE: begin
                env_phase = PH_RELEASE;
                env_count = 0;
            end
            default: ;
        endcase
        r.level = env_level[LEVEL_BITS-1:0];
        r.phase = env_phase;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (word %0d)", what, got, want, words_checked);
        err_count++;
    endtask

    // driver
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                w.func = i_func;
                w.key  = i_key;
                expected_results.push_back(env_step(w));
            end
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                i_in_valid <= 1'b1;
                i_func     <= w.func;
                i_key      <= w.key;
                if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 8);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word, level", o_level, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_level !== want.level) report_mismatch("level", o_level, want.level);
                if (o_phase !== want.phase) report_mismatch("phase", o_phase, want.phase);
            end
            words_checked++;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input longint unsigned data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DELAY:   base_len[SL_DELAY]   = data & LEN_MAX;
            CFG_ATTACK:  base_len[SL_ATTACK]  = data & LEN_MAX;
            CFG_HOLD:    base_len[SL_HOLD]    = data & LEN_MAX;
            CFG_DECAY:   base_len[SL_DECAY]   = data & LEN_MAX;
            CFG_SUSTAIN: sustain_cfg          = data & FULL_LVL;
            CFG_RELEASE: base_len[SL_RELEASE] = data & LEN_MAX;
            CFG_KEY_AMT: key_amt_cfg          = data[15:0];
            default: ;
        endcase
    endtask

    task automatic cfg_all(input longint unsigned dl, at, hd, dc, sus, rl, amt);
        cfg_write(CFG_DELAY, dl);
        cfg_write(CFG_ATTACK, at);
        cfg_write(CFG_HOLD, hd);
        cfg_write(CFG_DECAY, dc);
        cfg_write(CFG_SUSTAIN, sus);
        cfg_write(CFG_RELEASE, rl);
        cfg_write(CFG_KEY_AMT, amt);
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic push_word(input logic [FUNC_BITS-1:0] f, input logic [KEY_BITS-1:0] k);
        t_word w;
        w.func = f;
        w.key  = k;
        pending_words.push_back(w);
        if (f == FN_TRIGGER) triggers_sent++;
    endtask

    function automatic longint unsigned rand_len();
        case ($urandom_range(0, 9))
            0:       return 64'($urandom()) & LEN_MAX;
            1:       return 64'($urandom_range(20, 200));
            default: return 64'($urandom_range(0, 8));
        endcase
    endfunction

    task automatic push_random(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8)       push_word(FN_TRIGGER, KEY_BITS'($urandom()));
            else if (r < 14) push_word(FN_RELEASE, KEY_BITS'($urandom()));
            else if (r < 17) push_word(FN_UNUSED, KEY_BITS'($urandom()));
            else             push_word(FN_TICK, KEY_BITS'($urandom()));
        end
    endtask

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            base_len[i]   = 0;
            scaled_len[i] = 0;
        end
        sustain_cfg = 0;  sustain_held = 0;  key_amt_cfg = '0;
        env_phase = PH_IDLE;  env_count = 0;  env_level = 0;
        env_attack_start = 0;  env_release_start = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all lengths zero after reset: zero-length shortcuts, idle and unused code
        push_word(FN_UNUSED, 16'hffff);
        push_word(FN_TICK, 0);
        push_word(FN_RELEASE, 0);
        push_word(FN_TICK, 0);
        push_word(FN_TICK, 0);
        push_word(FN_TRIGGER, 16'h0000);
        repeat (6) push_word(FN_TICK, 16'hffff);
        push_word(FN_RELEASE, 0);
        push_word(FN_TICK, 0);
        wait_idle();

        // short phases, walk through every phase and retrigger mid-release
        cfg_all(2, 3, 1, 2, 16'h8000, 3, 0);
        cfg_write(CFG_UNUSED_IDX, 24'hffffff);
        push_word(FN_TRIGGER, 16'hffff);
        repeat (14) push_word(FN_TICK, 0);
        push_word(FN_RELEASE, 0);
        push_word(FN_TICK, 0);
        push_word(FN_TICK, 0);
        push_word(FN_TRIGGER, 16'h1234);
        repeat (3) push_word(FN_TICK, 0);
        wait_idle();

        // extreme lengths with full negative tracking at full key: all collapse to zero
        cfg_all(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, 16'hffff, LEN_MAX, 16'h8000);
        push_word(FN_TRIGGER, 16'hffff);
        repeat (6) push_word(FN_TICK, 0);
        push_word(FN_TRIGGER, 16'h0000);
        repeat (4) push_word(FN_TICK, 0);
        push_word(FN_RELEASE, 0);
        repeat (3) push_word(FN_TICK, 0);
        wait_idle();

        // full positive tracking, mid-size lengths
        cfg_all(5, 40, 3, 60, 16'h0000, 50, 16'h7fff);
        push_word(FN_TRIGGER, 16'h0000);
        repeat (60) push_word(FN_TICK, 0);
        push_random(60);
        wait_idle();

        for (int ph = 0; ph < 10; ph++) begin
            cfg_all(rand_len(), rand_len(), rand_len(), rand_len(), 64'($urandom()),
                    rand_len(), 64'($urandom()));
            if (ph == 9) calm = 1'b1;
            for (int s = 0; s < 10; s++) begin
                push_word(FN_TRIGGER, KEY_BITS'($urandom()));
                push_random($urandom_range(3, 11));
            end
            wait_idle();
        end

        $display("checked %0d result words over %0d triggers and 13 register settings",
                 words_checked, triggers_sent);
        $display("covered zero-length phases, extreme key tracking and random stalls");
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", err_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> key_tracked_dahdsr_envelope.f
hdl/kte_pkg.sv
hdl/kte_muldiv.sv
hdl/kte_dp.sv
hdl/kte_ctrl.sv
hdl/key_tracked_dahdsr_envelope.sv
tb/sv/key_tracked_dahdsr_envelope_tb.sv
